>>> rtl/lsc_pkg.sv
// Shared widths, register codes and flag types for the curvature stencil.
`default_nettype none
package lsc_pkg;

	// Field widths
	localparam int IN_W   = 28;  // one phi sample
	localparam int EPS_W  = 31;  // epsilon register
	localparam int OUT_W  = 19;  // curvature result
	localparam int MAG_W  = 30;  // |4*d|
	localparam int TM_W   = 29;  // |transverse sum|
	localparam int SQ_W   = 62;  // radicand
	localparam int RT_W   = 31;  // square root
	localparam int DR_W   = 32;  // divider partial remainder

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_CURV_EPS    = 1'b0,
		REG_SKIP_NONNEG = 1'b1
	} lsc_reg_t;

	// Per-component flags that ride along the sqrt and divide chains
	typedef struct packed {
		logic neg;   // difference was negative
		logic zero;  // root is zero, component forced to zero
	} lsc_nflag_t;

endpackage
`default_nettype wire

>>> rtl/lsc_sqrt_cell.sv
// One bit of the pipelined integer square root.
`default_nettype none
module lsc_sqrt_cell
	import lsc_pkg::*;
#(
	parameter int BIT = 0
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [SQ_W-1:0]  rem_i,
	input  wire logic [RT_W-1:0]  root_i,
	input  wire logic [MAG_W-1:0] mag_i,
	input  wire logic             neg_i,
	output logic      [SQ_W-1:0]  rem_o,
	output logic      [RT_W-1:0]  root_o,
	output logic      [MAG_W-1:0] mag_o,
	output logic                  neg_o
);

	logic [SQ_W-1:0] trial;
	logic            ge;

	// (root + 2^BIT)^2 - root^2
	assign trial = (SQ_W'(root_i) << (BIT + 1)) + (SQ_W'(1) << (2 * BIT));
	assign ge    = rem_i >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? rem_i - trial : rem_i;
			root_o <= ge ? (root_i | (RT_W'(1) << BIT)) : root_i;
			mag_o  <= mag_i;
			neg_o  <= neg_i;
		end
	end

endmodule
`default_nettype wire

>>> rtl/lsc_div_cell.sv
// One quotient bit of the pipelined restoring divider.
`default_nettype none
module lsc_div_cell
	import lsc_pkg::*;
#(
	parameter int QW    = 19,
	parameter int FIRST = 0
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [DR_W-1:0]  rem_i,
	input  wire logic [QW-1:0]    quo_i,
	input  wire logic [RT_W-1:0]  div_i,
	input  wire lsc_nflag_t       flag_i,
	output logic      [DR_W-1:0]  rem_o,
	output logic      [QW-1:0]    quo_o,
	output logic      [RT_W-1:0]  div_o,
	output lsc_nflag_t            flag_o
);

	logic [DR_W-1:0] part;
	logic            ge;

	// first cell takes the dividend as it is, the rest shift one bit in
	assign part = (FIRST != 0) ? rem_i : (rem_i << 1);
	assign ge   = part >= DR_W'(div_i);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? part - DR_W'(div_i) : part;
			quo_o  <= {quo_i[QW-2:0], ge};
			div_o  <= div_i;
			flag_o <= flag_i;
		end
	end

endmodule
`default_nettype wire

>>> rtl/lsc_normal.sv
// One normal component: squares, radicand, root chain, divide chain.
`default_nettype none
module lsc_normal
	import lsc_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int QW        = FRAC_BITS + 3
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [EPS_W-1:0] eps,
	input  wire logic [MAG_W-1:0] mag_in,
	input  wire logic [TM_W-1:0]  tm_in,
	input  wire logic             neg_in,
	output logic      [QW-1:0]    quo,
	output lsc_nflag_t            flag
);

	logic [MAG_W-1:0]   mag_s1, mag_s2, mag_s3;
	logic [TM_W-1:0]    tm_s1;
	logic               neg_s1, neg_s2, neg_s3;
	logic [2*MAG_W-1:0] msq_s2;
	logic [2*TM_W-1:0]  tsq_s2;
	logic [SQ_W-1:0]    rad_s3;

	// entry, squares, radicand
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_in;
			tm_s1  <= tm_in;
			neg_s1 <= neg_in;
			msq_s2 <= mag_s1 * mag_s1;
			tsq_s2 <= tm_s1 * tm_s1;
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			rad_s3 <= (SQ_W'(eps) << (FRAC_BITS + 4)) + SQ_W'(msq_s2) + SQ_W'(tsq_s2);
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
		end
	end

	// square root chain, one root bit per cell, top bit first
	logic [SQ_W-1:0]  rem_c  [0:RT_W];
	logic [RT_W-1:0]  root_c [0:RT_W];
	logic [MAG_W-1:0] mag_c  [0:RT_W];
	logic             neg_c  [0:RT_W];

	assign rem_c[0]  = rad_s3;
	assign root_c[0] = '0;
	assign mag_c[0]  = mag_s3;
	assign neg_c[0]  = neg_s3;

	for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
		lsc_sqrt_cell #(.BIT(RT_W - 1 - k)) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_i  (rem_c[k]),
			.root_i (root_c[k]),
			.mag_i  (mag_c[k]),
			.neg_i  (neg_c[k]),
			.rem_o  (rem_c[k+1]),
			.root_o (root_c[k+1]),
			.mag_o  (mag_c[k+1]),
			.neg_o  (neg_c[k+1])
		);
	end

	// divide chain: (mag << (FRAC_BITS+2)) / root, one quotient bit per cell
	logic [DR_W-1:0]  drem_c [0:QW];
	logic [QW-1:0]    quo_c  [0:QW];
	logic [RT_W-1:0]  dvs_c  [0:QW];
	lsc_nflag_t       flg_c  [0:QW];

	assign drem_c[0]     = DR_W'(mag_c[RT_W]);
	assign quo_c[0]      = '0;
	assign dvs_c[0]      = root_c[RT_W];
	assign flg_c[0].neg  = neg_c[RT_W];
	assign flg_c[0].zero = root_c[RT_W] == '0;

	for (genvar k = 0; k < QW; k++) begin : g_div
		lsc_div_cell #(.QW(QW), .FIRST((k == 0) ? 1 : 0)) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_i  (drem_c[k]),
			.quo_i  (quo_c[k]),
			.div_i  (dvs_c[k]),
			.flag_i (flg_c[k]),
			.rem_o  (drem_c[k+1]),
			.quo_o  (quo_c[k+1]),
			.div_o  (dvs_c[k+1]),
			.flag_o (flg_c[k+1])
		);
	end

	assign quo  = quo_c[QW];
	assign flag = flg_c[QW];

endmodule
`default_nettype wire

>>> rtl/level_set_curvature_stencil.sv
// Top level of the level-set mean-curvature stencil.
// One 3x3 window of phi (signed, FRAC_BITS fraction bits) enters per clock and one
// curvature word leaves per clock unless the output is held back. The path runs through
// an input register, four lanes with entry, squares and radicand registers, a 31-cell
// square-root chain and a FRAC_BITS+3 cell divide chain, then a combine and output
// register. Throughput is one window per cycle; when the output word is held
// back the whole pipe halts, so s_tready follows m_tready while a word is waiting.
// Skipped pixels go through the same pipe and come out with value and flag zero.
`default_nettype none
module level_set_curvature_stencil
	import lsc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// config write channel
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [0:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	// window in
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [255:0] s_tdata,  // center, right, left, up, down, up_right,
	                                    // up_left, down_right, down_left (28 b each)
	// curvature out
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [23:0]  m_tdata,  // curv_value [18:0]
	output logic      [0:0]   m_tuser   // write_valid
);

	localparam int QW   = FRAC_BITS + 3;
	localparam int LAT  = 3 + RT_W + QW;
	localparam int SUMW = QW + 4;
	localparam int CW   = (SUMW > OUT_W + 1) ? SUMW : OUT_W + 1;
	localparam int LIM_I = ((2 << FRAC_BITS) > 262143) ? 262143 : (2 << FRAC_BITS);
	localparam logic signed [CW-1:0] LIM = CW'(LIM_I);

	logic [EPS_W-1:0] eps_q;
	logic             skip_q;
	logic             adv, s_acc;
	logic             out_vld_q;
	logic [LAT:0]     vld_q, skp_q;

	// config registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q  <= EPS_W'(655);
			skip_q <= 1'b0;
		end else if (cfg_valid) begin
			case (lsc_reg_t'(cfg_index))
				REG_CURV_EPS:    eps_q  <= cfg_data[EPS_W-1:0];
				REG_SKIP_NONNEG: skip_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pipe advances whenever the output slot is free or being taken
	assign adv      = !out_vld_q || m_tready;
	assign s_tready = adv;
	assign s_acc    = s_tvalid && adv;

	// input register
	logic signed [IN_W-1:0] win_s1 [0:8];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 9; i++) begin
				win_s1[i] <= s_tdata[i*IN_W +: IN_W];
			end
		end
	end

	// valid and skip marks along the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			skp_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-1:0], s_acc};
			skp_q <= {skp_q[LAT-1:0], skip_q && !s_tdata[IN_W-1]};
		end
	end

	// differences and transverse sums
	logic signed [IN_W:0]   d_px, d_py, d_mx, d_my;
	logic signed [IN_W:0]   e_rd, e_ud, e_urdr, e_urul, e_uldl, e_drdl;
	logic signed [IN_W+1:0] t_px, t_py, t_mx, t_my;

	assign d_px   = (IN_W+1)'(win_s1[1]) - (IN_W+1)'(win_s1[0]);
	assign d_py   = (IN_W+1)'(win_s1[3]) - (IN_W+1)'(win_s1[0]);
	assign d_mx   = (IN_W+1)'(win_s1[0]) - (IN_W+1)'(win_s1[2]);
	assign d_my   = (IN_W+1)'(win_s1[0]) - (IN_W+1)'(win_s1[4]);
	assign e_rd   = (IN_W+1)'(win_s1[1]) - (IN_W+1)'(win_s1[2]);
	assign e_ud   = (IN_W+1)'(win_s1[3]) - (IN_W+1)'(win_s1[4]);
	assign e_urdr = (IN_W+1)'(win_s1[5]) - (IN_W+1)'(win_s1[7]);
	assign e_urul = (IN_W+1)'(win_s1[5]) - (IN_W+1)'(win_s1[6]);
	assign e_uldl = (IN_W+1)'(win_s1[6]) - (IN_W+1)'(win_s1[8]);
	assign e_drdl = (IN_W+1)'(win_s1[7]) - (IN_W+1)'(win_s1[8]);
	assign t_px   = (IN_W+2)'(e_urdr) + (IN_W+2)'(e_ud);
	assign t_py   = (IN_W+2)'(e_urul) + (IN_W+2)'(e_rd);
	assign t_mx   = (IN_W+2)'(e_uldl) + (IN_W+2)'(e_ud);
	assign t_my   = (IN_W+2)'(e_drdl) + (IN_W+2)'(e_rd);

	function automatic logic [MAG_W-1:0] mag4(input logic signed [IN_W:0] d);
		logic signed [IN_W:0] a;
		a = d[IN_W] ? -d : d;
		return {a[IN_W-1:0], 2'b00};
	endfunction

	function automatic logic [TM_W-1:0] tabs(input logic signed [IN_W+1:0] t);
		logic signed [IN_W+1:0] a;
		a = t[IN_W+1] ? -t : t;
		return a[TM_W-1:0];
	endfunction

	// four normal lanes: +x, +y, -x, -y
	logic signed [IN_W:0]   d_l [0:3];
	logic signed [IN_W+1:0] t_l [0:3];
	logic [QW-1:0]          q_l [0:3];
	lsc_nflag_t             f_l [0:3];
	logic signed [QW:0]     n_l [0:3];

	assign d_l[0] = d_px;  assign t_l[0] = t_px;
	assign d_l[1] = d_py;  assign t_l[1] = t_py;
	assign d_l[2] = d_mx;  assign t_l[2] = t_mx;
	assign d_l[3] = d_my;  assign t_l[3] = t_my;

	for (genvar g = 0; g < 4; g++) begin : g_lane
		lsc_normal #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_lane (
			.clk    (clk),
			.en     (adv),
			.eps    (eps_q),
			.mag_in (mag4(d_l[g])),
			.tm_in  (tabs(t_l[g])),
			.neg_in (d_l[g][IN_W]),
			.quo    (q_l[g]),
			.flag   (f_l[g])
		);
		assign n_l[g] = f_l[g].zero ? '0 :
			(f_l[g].neg ? -$signed({1'b0, q_l[g]}) : $signed({1'b0, q_l[g]}));
	end

	// halve the normal sum with rounding, drop two fraction bits, clamp
	logic signed [SUMW-1:0] s_sum, x_sum, cv_n;
	logic signed [CW-1:0]   cv_w, cv_c;

	always_comb begin
		s_sum = (SUMW'(n_l[0]) - SUMW'(n_l[2])) + (SUMW'(n_l[1]) - SUMW'(n_l[3]));
		x_sum = s_sum + SUMW'(4);
		cv_n  = x_sum >>> 3;
		cv_w  = CW'(cv_n);
		if (cv_w > LIM) begin
			cv_c = LIM;
		end else if (cv_w < -LIM) begin
			cv_c = -LIM;
		end else begin
			cv_c = cv_w;
		end
	end

	// output register
	logic [OUT_W-1:0] curv_q;
	logic             wv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_q[LAT];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			curv_q <= skp_q[LAT] ? '0 : cv_c[OUT_W-1:0];
			wv_q   <= !skp_q[LAT];
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = {5'b0, curv_q};
	assign m_tuser[0] = wv_q;

endmodule
`default_nettype wire

>>> rtl/lsc_checker.sv
// Port-level checks of the curvature stencil and their binding to the top level.
`default_nettype none
module lsc_checker #(
	parameter int FRAC_BITS = 16
) (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [23:0]  m_tdata,
	input wire logic [0:0]   m_tuser
);

	localparam int LIM_I = ((2 << FRAC_BITS) > 262143) ? 262143 : (2 << FRAC_BITS);
	localparam logic signed [19:0] LIM = 20'(LIM_I);

	logic signed [19:0] cv;
	assign cv = 20'($signed(m_tdata[18:0]));

	// held word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// a skipped pixel carries a zero value
	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 24'd0)
		else $error("skipped pixel with nonzero curvature");

	// result inside the saturation bound
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cv <= LIM) && (cv >= -LIM))
		else $error("curvature beyond saturation bound");

	// an empty output slot never blocks input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind level_set_curvature_stencil lsc_checker #(.FRAC_BITS(FRAC_BITS)) u_lsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

>>> test/level_set_curvature_stencil_check.sv
// Checker for the curvature stencil: watches the streams, predicts and compares.
`timescale 1ns / 100ps
`default_nettype none
module level_set_curvature_stencil_check
	import lsc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	input  wire logic         cfg_ready,
	input  wire logic [0:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [255:0] s_tdata,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [23:0]  m_tdata,
	input  wire logic [0:0]   m_tuser,
	output int                fail_count,
	output int                pending,
	output int                windows_seen,
	output int                words_seen
);

	typedef struct packed {
		logic signed [OUT_W-1:0] curv_value;
		logic                    write_valid;
	} curv_word_t;

	logic [EPS_W-1:0] eps_reg;
	logic             skip_reg;
	curv_word_t       curv_queue[$];

	// floor square root of a 64-bit value
	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] res, bits;
		res = 0;
		bits = 64'd1 << 62;
		while (bits > v) bits >>= 2;
		while (bits != 0) begin
			if (v >= res + bits) begin
				v = v - (res + bits);
				res = (res >> 1) + bits;
			end else begin
				res = res >> 1;
			end
			bits >>= 2;
		end
		return res;
	endfunction

	// one normal component, FRAC_BITS+2 fraction bits
	function automatic longint normal_part(input longint diff, input longint trans);
		longint a;
		logic [63:0] mag, tm, rad, rt, q;
		a = 4 * diff;
		mag = a < 0 ? -a : a;
		tm = trans < 0 ? -trans : trans;
		rad = ((64'(eps_reg) << FRAC_BITS) << 4) + mag * mag + tm * tm;
		rt = root_floor(rad);
		if (rt == 0) return 0;
		q = (mag << (FRAC_BITS + 2)) / rt;
		return a < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic curv_word_t curvature_of(input logic [255:0] win);
		longint p[9];
		longint npx, npy, nmx, nmy, sum, x, cv, lim;
		curv_word_t w;
		for (int i = 0; i < 9; i++)
			p[i] = longint'($signed(win[i*IN_W +: IN_W]));
		if (skip_reg && p[0] >= 0) begin
			w.curv_value = 0;
			w.write_valid = 0;
			return w;
		end
		// order: c r l u d ur ul dr dl
		npx = normal_part(p[1] - p[0], (p[5] - p[7]) + (p[3] - p[4]));
		npy = normal_part(p[3] - p[0], (p[5] - p[6]) + (p[1] - p[2]));
		nmx = normal_part(p[0] - p[2], (p[6] - p[8]) + (p[3] - p[4]));
		nmy = normal_part(p[0] - p[4], (p[7] - p[8]) + (p[1] - p[2]));
		sum = (npx - nmx) + (npy - nmy);
		x = sum + 4;
		cv = x >>> 3;
		lim = longint'(2) << FRAC_BITS;
		if (lim > 262143) lim = 262143;
		if (cv > lim) cv = lim;
		if (cv < -lim) cv = -lim;
		w.curv_value = cv[OUT_W-1:0];
		w.write_valid = 1;
		return w;
	endfunction

	assign pending = curv_queue.size();

	always @(posedge clk or negedge arst_n) begin
		curv_word_t want;
		if (!arst_n) begin
			eps_reg <= EPS_W'(655);
			skip_reg <= 1'b0;
			fail_count <= 0;
			windows_seen <= 0;
			words_seen <= 0;
			curv_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_CURV_EPS) eps_reg <= cfg_data[EPS_W-1:0];
				else if (cfg_index == REG_SKIP_NONNEG) skip_reg <= cfg_data[0];
			end
			if (s_tvalid && s_tready) begin
				curv_queue.push_back(curvature_of(s_tdata));
				windows_seen <= windows_seen + 1;
			end
			if (m_tvalid && m_tready) begin
				words_seen <= words_seen + 1;
				if (curv_queue.size() == 0) begin
					$error("curvature word with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					want = curv_queue.pop_front();
					if (m_tdata[OUT_W-1:0] !== want.curv_value) begin
						$error("curv_value expected %0d got %0d", want.curv_value,
							$signed(m_tdata[OUT_W-1:0]));
						fail_count <= fail_count + 1;
					end else if (m_tuser[0] !== want.write_valid) begin
						$error("write_valid expected %0d got %0d", want.write_valid,
							m_tuser[0]);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> test/level_set_curvature_stencil_test.sv
// Stimulus and verdict for the curvature stencil test.
`timescale 1ns / 100ps
`default_nettype none
module level_set_curvature_stencil_test;
	import lsc_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [0:0]   cfg_index;
	logic [31:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [255:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [23:0]  m_tdata;
	logic [0:0]   m_tuser;
	int           fail_count, pending, windows_seen, words_seen;
	int           burst_left;

	level_set_curvature_stencil uut (.*);
	level_set_curvature_stencil_check chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// receiver stalls on its own pattern, with calm stretches
	initial begin
		int phase;
		m_tready = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			phase = phase + 1;
			if ((phase / 300) % 3 == 1) m_tready <= 1;
			else m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// random window; mode picks small smooth values or wide raw bits
	function automatic logic [255:0] rand_window(input int mode);
		logic [255:0] w;
		int base;
		w = '0;
		base = $urandom_range(0, 1 << 20) - (1 << 19);
		for (int i = 0; i < 9; i++) begin
			if (mode == 0)
				w[i*IN_W +: IN_W] = IN_W'(base + $urandom_range(0, 1 << 17) - (1 << 16));
			else
				w[i*IN_W +: IN_W] = IN_W'($urandom);
		end
		return w;
	endfunction

	function automatic logic [255:0] fill_window(input logic [IN_W-1:0] c,
		input logic [IN_W-1:0] rest);
		logic [255:0] w;
		w = '0;
		w[0 +: IN_W] = c;
		for (int i = 1; i < 9; i++) w[i*IN_W +: IN_W] = rest;
		return w;
	endfunction

	task automatic send_window(input logic [255:0] w);
		if (burst_left == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		s_tvalid <= 1;
		s_tdata <= w;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
	endtask

	task automatic write_reg(input lsc_reg_t idx, input logic [31:0] val);
		s_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (70) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
	endtask

	initial begin
		logic [IN_W-1:0] maxv, minv;
		int waited;
		maxv = {1'b0, {(IN_W-1){1'b1}}};
		minv = {1'b1, {(IN_W-1){1'b0}}};
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		s_tvalid = 0;
		s_tdata = '0;
		burst_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, flat windows, steps, default, zero and largest epsilon
		send_window(fill_window(IN_W'(0), IN_W'(0)));
		send_window(fill_window(maxv, minv));
		send_window(fill_window(minv, maxv));
		send_window(fill_window(maxv, maxv));
		send_window(fill_window(minv, minv));
		send_window({88'd0, {5{IN_W'(1 << 16)}}, IN_W'(-(1 << 16))});
		send_window({4'd0, {4{IN_W'(-5)}}, {4{IN_W'(7)}}, IN_W'(0)});
		write_reg(REG_CURV_EPS, 0);
		send_window(fill_window(IN_W'(0), IN_W'(0)));
		send_window(fill_window(IN_W'(-3), IN_W'(-3)));
		send_window(fill_window(IN_W'(-1), IN_W'(1)));
		send_window(fill_window(maxv, minv));
		write_reg(REG_SKIP_NONNEG, 1);
		send_window(fill_window(IN_W'(0), minv));
		send_window(fill_window(IN_W'(-1), maxv));
		send_window(fill_window(maxv, IN_W'(0)));
		send_window(fill_window(minv, maxv));
		write_reg(REG_CURV_EPS, 32'h7FFF_FFFF);
		send_window(fill_window(minv, maxv));
		send_window(fill_window(IN_W'(-1), IN_W'(1)));
		send_window(rand_window(1));

		// random phases over several settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_CURV_EPS, 655); write_reg(REG_SKIP_NONNEG, 0); end
				1: write_reg(REG_CURV_EPS, 1);
				2: write_reg(REG_SKIP_NONNEG, 1);
				3: write_reg(REG_CURV_EPS, $urandom);
				4: begin write_reg(REG_CURV_EPS, 32'h7FFF_FFFF);
					write_reg(REG_SKIP_NONNEG, 0); end
				default: write_reg(REG_CURV_EPS, $urandom_range(1, 1 << 16));
			endcase
			for (int i = 0; i < 65; i++)
				send_window(rand_window($urandom_range(0, 3) == 0));
		end
		s_tvalid <= 0;

		waited = 0;
		while (pending != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		$display("Sent %0d windows over several epsilon and skip settings, %0d words back.",
			windows_seen, words_seen);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
rtl/lsc_pkg.sv
rtl/lsc_sqrt_cell.sv
rtl/lsc_div_cell.sv
rtl/lsc_normal.sv
rtl/level_set_curvature_stencil.sv
rtl/lsc_checker.sv
test/level_set_curvature_stencil_check.sv
test/level_set_curvature_stencil_test.sv
